// File: rtl/core/hsv_hue_rotate_pixel_macros.svh
// ----------------------------------------------------------------------------
// HSV hue rotation assertion macros
// Shared concurrent assertion wrappers; clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef HSV_HUE_ROTATE_PIXEL_MACROS_SVH
`define HSV_HUE_ROTATE_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF
`define HSVR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define HSVR_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`else
`define HSVR_ASSERT(lbl, prop, msg)
`define HSVR_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

// File: rtl/core/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// HSV hue rotation package
// Register map, reset values, reciprocal constants and the side-band type.
// ----------------------------------------------------------------------------
package hsvr_pkg;

	localparam int PIX_W = 8;

	typedef enum logic [1:0] {
		REG_HUE_SHIFT   = 2'd0,
		REG_WINDOW_LOW  = 2'd1,
		REG_WINDOW_HIGH = 2'd2
	} reg_idx_t;

	localparam logic [8:0] RST_HUE_SHIFT   = 9'd0;
	localparam logic [8:0] RST_WINDOW_LOW  = 9'd70;
	localparam logic [8:0] RST_WINDOW_HIGH = 9'd180;

	// floor(x/255) == (x * RECIP_255) >> 23 for any 16-bit x
	localparam logic [16:0] RECIP_255 = 17'h08081;
	// floor(z/15) == (z * RECIP_15) >> 20 for z below 74898
	localparam logic [16:0] RECIP_15  = 17'd69906;

	// item data carried alongside the dividers
	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
		logic             sel;
		logic [PIX_W-1:0] v;
		logic             gray;
		logic [8:0]       base;   // sector base hue, degrees
	} side_t;

endpackage

// File: rtl/core/hsvr_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; extra stages up to LAT only hold the result.
// Caller guarantees num < den * 2^Q_W.
// ----------------------------------------------------------------------------
module hsvr_div #(
	parameter int DEN_W = 8,
	parameter int Q_W   = 12,
	parameter int LAT   = 12
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [Q_W+DEN_W-1:0]   num,
	input  logic [DEN_W-1:0]       den,
	output logic [Q_W-1:0]         quo
);

	logic [DEN_W-1:0] rem_s  [LAT];
	logic [DEN_W-1:0] den_s  [LAT];
	logic [Q_W-1:0]   bits_s [LAT];
	logic [Q_W-1:0]   quo_s  [LAT];

	for (genvar i = 0; i < LAT; i++) begin : g_stage
		logic [DEN_W-1:0] p_rem;
		logic [DEN_W-1:0] p_den;
		logic [Q_W-1:0]   p_bits;
		logic [Q_W-1:0]   p_quo;
		logic [DEN_W-1:0] n_rem;
		logic [Q_W-1:0]   n_bits;
		logic [Q_W-1:0]   n_quo;

		if (i == 0) begin : g_first
			assign p_rem  = num[Q_W+DEN_W-1:Q_W];
			assign p_bits = num[Q_W-1:0];
			assign p_quo  = '0;
			assign p_den  = den;
		end else begin : g_next
			assign p_rem  = rem_s[i-1];
			assign p_bits = bits_s[i-1];
			assign p_quo  = quo_s[i-1];
			assign p_den  = den_s[i-1];
		end

		if (i < Q_W) begin : g_step
			logic [DEN_W:0] trial;
			logic [DEN_W:0] diff;
			logic           ge;
			always_comb begin
				trial  = {p_rem, p_bits[Q_W-1]};
				diff   = trial - {1'b0, p_den};
				ge     = (trial >= {1'b0, p_den});
				n_rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				n_bits = p_bits << 1;
				n_quo  = (p_quo << 1) | Q_W'(ge);
			end
		end else begin : g_hold
			assign n_rem  = p_rem;
			assign n_bits = p_bits;
			assign n_quo  = p_quo;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= n_rem;
				bits_s[i] <= n_bits;
				quo_s[i]  <= n_quo;
				den_s[i]  <= p_den;
			end
		end
	end

	assign quo = quo_s[LAT-1];

endmodule

// File: rtl/core/hsv_hue_rotate_pixel.sv
// ----------------------------------------------------------------------------
// HSV hue rotation of one RGB pixel
// Divider depth: LAT = max(clog2(60*2^F + 1), 8).
// Throughput: one item per clock unless a stalled output halts the pipe;
//   the hue divider pipeline (one quotient bit per stage) sets depth, not rate.
// Reset: arst_n clears all valid bits and loads hue_shift = 0,
//   window_low = 70, window_high = 180. No clearing pass.
// ----------------------------------------------------------------------------
`include "hsv_hue_rotate_pixel_macros.svh"

module hsv_hue_rotate_pixel #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic        selected,
	// item out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        hue_in_window
);

	localparam int F    = HUE_FRAC_BITS;
	localparam int ONE  = 1 << F;
	localparam int U    = 60 * ONE;          // one sector
	localparam int FULL = 360 * ONE;         // full turn
	localparam int HW   = F + 9;             // hue width
	localparam int QW   = $clog2(U + 1);     // hue quotient width
	localparam int LAT  = (QW > 8) ? QW : 8; // divider depth
	localparam int PW   = HW + 8;            // c*f product width

	// ------------------------------------------------------------------
	// Config registers. Only written by the user while the pipeline is empty,
	// so the stages read them directly; the block itself does not enforce it.
	// ------------------------------------------------------------------
	logic signed [8:0] hue_shift_q;
	logic [8:0]        window_low_q;
	logic [8:0]        window_high_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q   <= hsvr_pkg::RST_HUE_SHIFT;
			window_low_q  <= hsvr_pkg::RST_WINDOW_LOW;
			window_high_q <= hsvr_pkg::RST_WINDOW_HIGH;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				hsvr_pkg::REG_HUE_SHIFT:   hue_shift_q   <= pwdata[8:0];
				hsvr_pkg::REG_WINDOW_LOW:  window_low_q  <= pwdata[8:0];
				hsvr_pkg::REG_WINDOW_HIGH: window_high_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			hsvr_pkg::REG_HUE_SHIFT:   prdata = {23'd0, hue_shift_q};
			hsvr_pkg::REG_WINDOW_LOW:  prdata = {23'd0, window_low_q};
			hsvr_pkg::REG_WINDOW_HIGH: prdata = {23'd0, window_high_q};
			default:                   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: the whole pipe moves together; it only halts when the
	// output register holds an item that is being stalled.
	// ------------------------------------------------------------------
	logic en;
	logic vld_s5;

	assign en       = !(vld_s5 && out_stall);
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// Stage 1: max/min, sector pick. Negative numerators are folded into
	// the previous sector so the divider only sees nonnegative values:
	// hue = base + floor(U * n / d), 0 <= n <= d.
	// ------------------------------------------------------------------
	logic [7:0] mx, mn, dd, nn;
	logic [8:0] base;

	always_comb begin
		mx = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx)  mx = blue_in;
		mn = red_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn)  mn = blue_in;
		dd = mx - mn;
		priority if (mx == red_in) begin
			if (green_in >= blue_in) begin
				base = 9'd0;   nn = green_in - blue_in;
			end else begin
				base = 9'd300; nn = dd - (blue_in - green_in);
			end
		end else if (mx == green_in) begin
			if (blue_in >= red_in) begin
				base = 9'd120; nn = blue_in - red_in;
			end else begin
				base = 9'd60;  nn = dd - (red_in - blue_in);
			end
		end else begin
			if (red_in >= green_in) begin
				base = 9'd240; nn = red_in - green_in;
			end else begin
				base = 9'd180; nn = dd - (green_in - red_in);
			end
		end
	end

	logic                vld_s1;
	hsvr_pkg::side_t     side_s1;
	logic [7:0]          n_s1;
	logic [7:0]          d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.r    <= red_in;
			side_s1.g    <= green_in;
			side_s1.b    <= blue_in;
			side_s1.sel  <= selected;
			side_s1.v    <= mx;
			side_s1.gray <= (dd == 8'd0);
			side_s1.base <= base;
			n_s1         <= nn;
			d_s1         <= dd;
		end
	end

	// ------------------------------------------------------------------
	// Dividers: hue fraction U*n/d and saturation 255*d/mx, side by side.
	// ------------------------------------------------------------------
	logic [QW+7:0]  hue_num;
	logic [15:0]    sat_num;
	logic [QW-1:0]  hue_q;
	logic [7:0]     sat_q;

	assign hue_num = (QW+8)'(U) * (QW+8)'(n_s1);
	assign sat_num = 16'(8'd255 * d_s1);

	hsvr_div #(.DEN_W(8), .Q_W(QW), .LAT(LAT)) u_hue_div (
		.clk (clk), .en (en), .num (hue_num), .den (d_s1), .quo (hue_q)
	);

	hsvr_div #(.DEN_W(8), .Q_W(8), .LAT(LAT)) u_sat_div (
		.clk (clk), .en (en), .num (sat_num), .den (side_s1.v), .quo (sat_q)
	);

	logic            vld_d  [LAT];
	hsvr_pkg::side_t side_d [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_d[i] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= vld_s1;
			for (int i = 1; i < LAT; i++) vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s1;
			for (int i = 1; i < LAT; i++) side_d[i] <= side_d[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: finish hue, window flag, add shift and wrap, v*s8.
	// ------------------------------------------------------------------
	hsvr_pkg::side_t    sd;
	logic [HW-1:0]      hue;
	logic [7:0]         s8;
	logic               flag;
	logic signed [HW+1:0] hs;
	logic signed [HW+1:0] sh_ext;
	logic [HW-1:0]      hw;

	assign sd = side_d[LAT-1];

	always_comb begin
		hue    = sd.gray ? '0 : ((HW'(sd.base) << F) + HW'(hue_q));
		s8     = (sd.v == 8'd0) ? 8'd0 : sat_q;
		flag   = (hue > (HW'(window_low_q) << F)) && (hue < (HW'(window_high_q) << F));
		sh_ext = (HW+2)'(hue_shift_q) <<< F;
		hs     = $signed({2'b00, hue}) + sh_ext;
		// shift spans -256..255 degrees: one correction is always enough
		priority if (hs < 0)
			hw = HW'(hs + $signed((HW+2)'(FULL)));
		else if (hs >= $signed((HW+2)'(FULL)))
			hw = HW'(hs - $signed((HW+2)'(FULL)));
		else
			hw = HW'(hs);
	end

	logic            vld_s2;
	hsvr_pkg::side_t side_s2;
	logic            flag_s2;
	logic [HW-1:0]   h_s2;
	logic [15:0]     x_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_d[LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= sd;
			flag_s2 <= flag;
			h_s2    <= hw;
			x_s2    <= 16'(sd.v * s8);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: c = floor(v*s8/255) and sector k = floor(h/U), both by
	// reciprocal multiply.
	// ------------------------------------------------------------------
	logic [32:0] c_prod;
	logic [6:0]  hd;
	logic [23:0] k_prod;

	always_comb begin
		c_prod = 33'(x_s2) * 33'(hsvr_pkg::RECIP_255);
		hd     = 7'(h_s2 >> (F + 2));
		k_prod = 24'(hd) * 24'(hsvr_pkg::RECIP_15);
	end

	logic            vld_s3;
	hsvr_pkg::side_t side_s3;
	logic            flag_s3;
	logic [HW-1:0]   h_s3;
	logic [7:0]      c_s3;
	logic [2:0]      k_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			flag_s3 <= flag_s2;
			h_s3    <= h_s2;
			c_s3    <= c_prod[30:23];
			k_s3    <= k_prod[22:20];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: fraction f, lo = v - c, products c*f and c*(U-f).
	// ------------------------------------------------------------------
	logic [HW-1:0] f;
	logic [HW-1:0] fc;

	always_comb begin
		f  = h_s3 - HW'(k_s3 * HW'(U));
		fc = HW'(U) - f;
	end

	logic            vld_s4;
	hsvr_pkg::side_t side_s4;
	logic            flag_s4;
	logic [7:0]      lo_s4;
	logic [2:0]      k_s4;
	logic [PW-1:0]   pf_s4;
	logic [PW-1:0]   pg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			flag_s4 <= flag_s3;
			lo_s4   <= side_s3.v - c_s3;
			k_s4    <= k_s3;
			pf_s4   <= PW'(c_s3) * PW'(f);
			pg_s4   <= PW'(c_s3) * PW'(fc);
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: divide by U (shift by F+2, then /15), six-sector rebuild,
	// unselected pixels passed through unchanged, output register.
	// ------------------------------------------------------------------
	logic [11:0] zf, zg;
	logic [28:0] rf_prod, rg_prod;
	logic [7:0]  rise, fall, v4, lo4;
	logic [7:0]  ro, go, bo;

	always_comb begin
		zf      = 12'(pf_s4 >> (F + 2));
		zg      = 12'(pg_s4 >> (F + 2));
		rf_prod = 29'(zf) * 29'(hsvr_pkg::RECIP_15);
		rg_prod = 29'(zg) * 29'(hsvr_pkg::RECIP_15);
		v4      = side_s4.v;
		lo4     = lo_s4;
		rise    = lo4 + rf_prod[27:20];
		fall    = lo4 + rg_prod[27:20];
		unique case (k_s4)
			3'd0:    begin ro = v4;   go = rise; bo = lo4;  end
			3'd1:    begin ro = fall; go = v4;   bo = lo4;  end
			3'd2:    begin ro = lo4;  go = v4;   bo = rise; end
			3'd3:    begin ro = lo4;  go = fall; bo = v4;   end
			3'd4:    begin ro = rise; go = lo4;  bo = v4;   end
			default: begin ro = v4;   go = lo4;  bo = fall; end
		endcase
		if (!side_s4.sel) begin
			ro = side_s4.r;
			go = side_s4.g;
			bo = side_s4.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_out       <= ro;
			green_out     <= go;
			blue_out      <= bo;
			hue_in_window <= flag_s4;
		end
	end

	assign out_valid = vld_s5;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`HSVR_ASSERT_IMPL(a_hue_wrapped, vld_s2, h_s2 < HW'(FULL), "shifted hue not wrapped")
	`HSVR_ASSERT_IMPL(a_sector_range, vld_s3, k_s3 <= 3'd5, "hue sector out of range")
	`HSVR_ASSERT_IMPL(a_rebuild_bound, vld_s4, (rise <= v4) && (fall <= v4),
		"rebuilt component above value")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV hue rotation pixel testbench
// Drives RGB pixels with random valid gaps and output stalls, predicts each
// result from its own fixed-point HSV model, and checks results in order.
// Registers are rewritten over several settings while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FRAC     = 6;
	localparam int HUE_UNIT = 60 << FRAC;
	localparam int HUE_FULL = 360 << FRAC;
	localparam int LATENCY  = 17;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       sel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       win;
	} recolor_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  red_in = '0, green_in = '0, blue_in = '0;
	logic        selected = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red_out, green_out, blue_out;
	logic        hue_in_window;

	// register shadow used by the predictor
	int shift_deg = 0;
	int win_lo = 70;
	int win_hi = 180;

	pixel_t   pending_pixels[$];
	recolor_t expected_pixels[$];
	int       errors = 0;
	bit       quiet_mode = 1'b0;   // no idling on either side
	int       hold_cycles = 0;     // long receiver hold-off
	bit       in_taken = 1'b0;     // input item accepted at the last rising edge

	always #4 clk = ~clk;

	hsv_hue_rotate_pixel #(.HUE_FRAC_BITS(FRAC)) i_dut (.*);

	// Fixed-point HSV forward, shift, six-sector rebuild.
	function automatic recolor_t rotate_pixel(pixel_t p);
		int r, g, b, mx, mn, d, hue, s8, h, c, lo, k, f, rise, fall;
		int num, off;
		recolor_t o;
		r = p.r; g = p.g; b = p.b;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		hue = 0;
		s8 = 0;
		if (d != 0) begin
			if (mx == r) begin
				num = g - b; off = (g < b) ? 360 : 0;
			end else if (mx == g) begin
				num = b - r; off = 120;
			end else begin
				num = r - g; off = 240;
			end
			hue = (HUE_UNIT * num + (off << FRAC) * d) / d;
			if (hue >= HUE_FULL) hue -= HUE_FULL;
			if (hue < 0) hue += HUE_FULL;
		end
		if (mx != 0) s8 = (255 * d) / mx;
		o.win = (hue > (win_lo << FRAC)) && (hue < (win_hi << FRAC));
		if (!p.sel) begin
			o.r = p.r; o.g = p.g; o.b = p.b;
			return o;
		end
		h = hue + shift_deg * (1 << FRAC);
		while (h < 0) h += HUE_FULL;
		while (h >= HUE_FULL) h -= HUE_FULL;
		c = (mx * s8) / 255;
		lo = mx - c;
		k = h / HUE_UNIT;
		f = h - k * HUE_UNIT;
		rise = lo + (c * f) / HUE_UNIT;
		fall = lo + (c * (HUE_UNIT - f)) / HUE_UNIT;
		// all values already lie in 0..255, so no clamp is needed
		case (k)
			0: begin o.r = mx;   o.g = rise; o.b = lo;   end
			1: begin o.r = fall; o.g = mx;   o.b = lo;   end
			2: begin o.r = lo;   o.g = mx;   o.b = rise; end
			3: begin o.r = lo;   o.g = fall; o.b = mx;   end
			4: begin o.r = rise; o.g = lo;   o.b = mx;   end
			default: begin o.r = mx; o.g = lo; o.b = fall; end
		endcase
		return o;
	endfunction

	// Input acceptance is sampled at the rising edge; predict right there.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			in_taken = 1'b1;
			expected_pixels.push_back(rotate_pixel(pending_pixels.pop_front()));
		end
	end

	// Driver: offers the head of the queue, holds it until accepted.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_pixels.size() != 0 && (quiet_mode || $urandom_range(99) >= 23)) begin
					in_valid <= 1'b1;
					{red_in, green_in, blue_in, selected} <= pending_pixels[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, with an occasional long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_mode && ($urandom_range(99) < 23);
			end
		end
	end

	// Monitor: compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		recolor_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result rgb=%h %h %h win=%b", $realtime,
					red_out, green_out, blue_out, hue_in_window);
			end else begin
				want = expected_pixels.pop_front();
				if (want.r !== red_out) begin
					errors++;
					$display("%0t: red expected %h got %h", $realtime, want.r, red_out);
				end
				if (want.g !== green_out) begin
					errors++;
					$display("%0t: green expected %h got %h", $realtime, want.g, green_out);
				end
				if (want.b !== blue_out) begin
					errors++;
					$display("%0t: blue expected %h got %h", $realtime, want.b, blue_out);
				end
				if (want.win !== hue_in_window) begin
					errors++;
					$display("%0t: window expected %b got %b", $realtime, want.win,
						hue_in_window);
				end
			end
		end
	end

	task automatic write_reg(hsvr_pkg::reg_idx_t idx, logic [8:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 4'(idx) << 2; pwdata <= {23'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			hsvr_pkg::REG_HUE_SHIFT: shift_deg = $signed(value);
			hsvr_pkg::REG_WINDOW_LOW: win_lo = value;
			default: win_hi = value;
		endcase
	endtask

	// Waits until every queued item is in and every result has come back.
	task automatic drain();
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || in_valid)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.r = $urandom; p.g = $urandom; p.b = $urandom;
		case ($urandom_range(7))
			0: begin p.g = p.r; p.b = p.r; end   // gray
			1: p.g = p.r;                        // ties between two components
			2: p.b = p.g;
			3: p.r = p.b;
			default: ;
		endcase
		p.sel = ($urandom_range(3) != 0);
		return p;
	endfunction

	initial begin
		logic [8:0] shifts[8] = '{9'd0, 9'h14C, 9'd180, 9'h100, 9'd255, 9'd90, 9'h1C4, 9'd1};
		logic [8:0] lows[8]   = '{9'd70, 9'd0, 9'd359, 9'd0, 9'd511, 9'd200, 9'd30, 9'd180};
		logic [8:0] highs[8]  = '{9'd180, 9'd360, 9'd0, 9'd511, 9'd100, 9'd300, 9'd31, 9'd360};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, gray/black/white, primaries, red-sector wrap
		quiet_mode = 1'b1;
		pending_pixels.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
		pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b1});
		pending_pixels.push_back('{8'd128, 8'd128, 8'd128, 1'b0});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd0, 1'b1});
		pending_pixels.push_back('{8'd0, 8'd255, 8'd0, 1'b1});
		pending_pixels.push_back('{8'd0, 8'd0, 8'd255, 1'b1});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd1, 1'b1});
		pending_pixels.push_back('{8'd255, 8'd255, 8'd0, 1'b1});
		pending_pixels.push_back('{8'd0, 8'd255, 8'd255, 1'b0});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd255, 1'b1});
		pending_pixels.push_back('{8'd1, 8'd0, 8'd0, 1'b1});
		pending_pixels.push_back('{8'd170, 8'd85, 8'd255, 1'b1});
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			write_reg(hsvr_pkg::REG_HUE_SHIFT, shifts[phase]);
			write_reg(hsvr_pkg::REG_WINDOW_LOW, lows[phase]);
			write_reg(hsvr_pkg::REG_WINDOW_HIGH, highs[phase]);
			quiet_mode = (phase == 2);
			for (int n = 0; n < 218; n++) pending_pixels.push_back(random_pixel());
			if (phase == 4) begin
				// let the sender fill the pipe while the receiver holds off
				@(negedge clk);
				hold_cycles = 300;
			end
			drain();
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hsvr_pkg.sv
rtl/core/hsvr_div.sv
rtl/core/hsv_hue_rotate_pixel.sv
bench/testbench.sv
